// ===== rtl/msr_pkg.sv =====
// Shared types and constants for the merge sort range block.
// Used by the interfaces, the register file, the controller, the datapath and the checker.
package msr_pkg;

  localparam int ELEM_W  = 32;
  localparam int RANGE_W = 10;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [RANGE_W-1:0]       range_t;

  // Operation codes of an input request
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Register indexes (address bit 2)
  localparam logic REG_RANGE_START = 1'b0;
  localparam logic REG_RANGE_END   = 1'b1;

  localparam range_t RANGE_START_RST = 10'd0;
  localparam range_t RANGE_END_RST   = 10'd1023;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic read;
    logic sort_init;
    logic seg_start;
    logic seg_second;
    logic merge;
  } msr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pend;
    logic sort_go;
    logic pass_finish;
    logic seg_end;
    logic pass_end;
  } msr_stat_t;

endpackage

// ===== rtl/msr_if.sv =====
// Request and result channel interfaces for the merge sort range block.
// Depends on msr_pkg for the payload types.
interface msr_in_if;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  msr_pkg::elem_t        value;
  logic                  last;
  msr_pkg::range_t       index;

  modport source (output valid, output operation, output value, output last, output index,
                  input ready);
  modport sink   (input valid, input operation, input value, input last, input index,
                  output ready);
endinterface

interface msr_out_if;
  logic                  valid;
  logic                  ready;
  msr_pkg::elem_t        element;
  logic                  out_of_range;

  modport source (output valid, output element, output out_of_range, input ready);
  modport sink   (input valid, input element, input out_of_range, output ready);
endinterface

// ===== rtl/msr_regs.sv =====
// APB-style register file holding the sort range bounds.
// Depends on msr_pkg for register indexes and reset values.
module msr_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msr_pkg::CFG_AW-1:0]  paddr,
  input  logic [msr_pkg::CFG_DW-1:0]  pwdata,
  output logic [msr_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output msr_pkg::range_t             range_start,
  output msr_pkg::range_t             range_end
);

  msr_pkg::range_t range_start_r;
  msr_pkg::range_t range_end_r;
  logic            wr_en;
  logic            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  // Capture register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= msr_pkg::RANGE_START_RST;
      range_end_r   <= msr_pkg::RANGE_END_RST;
    end else if (wr_en) begin
      case (reg_idx)
        msr_pkg::REG_RANGE_START: range_start_r <= pwdata[msr_pkg::RANGE_W-1:0];
        msr_pkg::REG_RANGE_END:   range_end_r   <= pwdata[msr_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended
  always_comb begin
    case (reg_idx)
      msr_pkg::REG_RANGE_START: prdata = msr_pkg::CFG_DW'(range_start_r);
      msr_pkg::REG_RANGE_END:   prdata = msr_pkg::CFG_DW'(range_end_r);
      default:                  prdata = '0;
    endcase
  end

  assign range_start = range_start_r;
  assign range_end   = range_end_r;

endmodule

// ===== rtl/msr_ctrl.sv =====
// Controller for the merge sort range block: request handshake and sort sequencing.
// Depends on msr_pkg for the command and status structs and the operation codes.
module msr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_operation,
  input  logic                in_last,
  output logic                in_ready,
  output msr_pkg::msr_cmd_t   cmd,
  input  msr_pkg::msr_stat_t  st
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_SEG_A,
    S_SEG_B,
    S_MERGE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;

  assign in_ready = (state_r == S_IDLE) && !st.pend;
  assign in_fire  = in_valid && in_ready;

  // Issue datapath commands
  always_comb begin
    cmd            = '0;
    cmd.load       = in_fire && (in_operation == msr_pkg::OP_LOAD);
    cmd.read       = in_fire && (in_operation == msr_pkg::OP_READ);
    cmd.sort_init  = cmd.load && in_last && st.sort_go;
    cmd.seg_start  = (state_r == S_SEG_A);
    cmd.seg_second = (state_r == S_SEG_B);
    cmd.merge      = (state_r == S_MERGE);
  end

  // Advance through passes and segments
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (cmd.sort_init) state_nxt = S_PASS;
      S_PASS:  state_nxt = st.pass_finish ? S_IDLE : S_SEG_A;
      S_SEG_A: state_nxt = S_SEG_B;
      S_SEG_B: state_nxt = S_MERGE;
      S_MERGE: begin
        if (st.seg_end) state_nxt = st.pass_end ? S_PASS : S_SEG_A;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/msr_dp.sv =====
// Datapath for the merge sort range block: element store, scratch store, merge
// pointers, count and result register. Depends on msr_pkg for types and command structs.
module msr_dp #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  msr_pkg::msr_cmd_t   cmd,
  output msr_pkg::msr_stat_t  st,
  input  msr_pkg::elem_t      in_value,
  input  logic                in_last,
  input  msr_pkg::range_t     in_index,
  input  msr_pkg::range_t     range_start,
  input  msr_pkg::range_t     range_end,
  output logic                out_valid,
  input  logic                out_ready,
  output msr_pkg::elem_t      out_element,
  output logic                out_of_range
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int LW = (CW > msr_pkg::RANGE_W) ? CW : msr_pkg::RANGE_W;
  localparam int PW = AW + 4;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

  // Element store and merge scratch
  msr_pkg::elem_t store_r   [MAX_ELEMENTS];
  msr_pkg::elem_t scratch_r [MAX_ELEMENTS];
  msr_pkg::elem_t a_rdata_r;
  msr_pkg::elem_t b_rdata_r;

  logic [CW-1:0]  count_r;
  logic           set_open_r;

  // Sort state
  logic [AW-1:0]  lo_r;
  logic [AW-1:0]  hi_r;
  logic [PW-1:0]  w_r;
  logic           dir_r;
  logic [PW-1:0]  seg_l_r;
  logic [PW-1:0]  seg_mid_r;
  logic [PW-1:0]  seg_hi_r;
  logic [PW-1:0]  a_r;
  logic [PW-1:0]  b_r;
  logic [PW-1:0]  k_r;
  msr_pkg::elem_t head_l_r;
  msr_pkg::elem_t head_r_r;
  logic           pend_left_r;

  // Result path
  logic           pend_r;
  logic           pend_oor_r;
  logic           out_valid_r;
  msr_pkg::elem_t out_elem_r;
  logic           out_oor_r;

  logic [CW-1:0]  cnt_base;
  logic           room;
  logic [CW-1:0]  cnt_new;
  logic [LW-1:0]  end_lim;
  logic [LW-1:0]  rstart_ext;
  logic [LW-1:0]  rend_ext;
  logic [LW-1:0]  hi_cand;
  logic [LW-1:0]  idx_ext;
  logic           hit;
  logic           move;

  logic [PW-1:0]  len;
  logic [PW-1:0]  hi_ext;
  logic [PW-1:0]  mid_raw;
  logic [PW-1:0]  mid_c;
  logic [PW-1:0]  sh_raw;
  logic [PW-1:0]  sh_c;

  msr_pkg::elem_t src_rdata;
  msr_pkg::elem_t eff_l;
  msr_pkg::elem_t eff_r;
  logic           l_ex;
  logic           r_ex;
  logic           take_l;
  msr_pkg::elem_t merge_wdata;

  logic           src_re;
  logic [AW-1:0]  src_raddr;
  logic           a_re;
  logic [AW-1:0]  a_raddr;
  logic           a_we;
  logic [AW-1:0]  a_waddr;
  msr_pkg::elem_t a_wdata;
  logic           b_re;
  logic           b_we;

  // Load count and clamped range end
  assign cnt_base   = set_open_r ? count_r : '0;
  assign room       = cnt_base < MAX_C;
  assign cnt_new    = room ? cnt_base + CW'(1) : cnt_base;
  assign end_lim    = LW'(cnt_new) - LW'(1);
  assign rstart_ext = LW'(range_start);
  assign rend_ext   = LW'(range_end);
  assign hi_cand    = (rend_ext > end_lim) ? end_lim : rend_ext;
  assign idx_ext    = LW'(in_index);
  assign hit        = idx_ext < LW'(count_r);

  // Segment bounds for the current width
  assign hi_ext  = PW'(hi_r);
  assign len     = hi_ext - PW'(lo_r) + PW'(1);
  assign mid_raw = seg_l_r + w_r - PW'(1);
  assign mid_c   = (mid_raw > hi_ext) ? hi_ext : mid_raw;
  assign sh_raw  = seg_l_r + (w_r << 1) - PW'(1);
  assign sh_c    = (sh_raw > hi_ext) ? hi_ext : sh_raw;

  // Merge decision; the side read last cycle comes straight from the store
  assign src_rdata   = dir_r ? b_rdata_r : a_rdata_r;
  assign eff_l       = pend_left_r ? src_rdata : head_l_r;
  assign eff_r       = pend_left_r ? head_r_r : src_rdata;
  assign l_ex        = a_r > seg_mid_r;
  assign r_ex        = b_r > seg_hi_r;
  assign take_l      = r_ex || (!l_ex && (eff_l <= eff_r));
  assign merge_wdata = take_l ? eff_l : eff_r;

  // Source read port selection
  always_comb begin
    src_re    = 1'b0;
    src_raddr = seg_l_r[AW-1:0];
    if (cmd.seg_start) begin
      src_re    = 1'b1;
      src_raddr = seg_l_r[AW-1:0];
    end else if (cmd.seg_second) begin
      src_re    = 1'b1;
      src_raddr = b_r[AW-1:0];
    end else if (cmd.merge) begin
      src_re    = 1'b1;
      src_raddr = take_l ? (a_r[AW-1:0] + AW'(1)) : (b_r[AW-1:0] + AW'(1));
    end
  end

  assign a_re    = cmd.read || (src_re && !dir_r);
  assign a_raddr = cmd.read ? idx_ext[AW-1:0] : src_raddr;
  assign a_we    = (cmd.load && room) || (cmd.merge && dir_r);
  assign a_waddr = cmd.load ? cnt_base[AW-1:0] : k_r[AW-1:0];
  assign a_wdata = cmd.load ? in_value : merge_wdata;
  assign b_re    = src_re && dir_r;
  assign b_we    = cmd.merge && !dir_r;

  // Element store
  always_ff @(posedge clk) begin
    if (a_we) store_r[a_waddr] <= a_wdata;
    if (a_re) a_rdata_r <= store_r[a_raddr];
  end

  // Merge scratch
  always_ff @(posedge clk) begin
    if (b_we) scratch_r[k_r[AW-1:0]] <= merge_wdata;
    if (b_re) b_rdata_r <= scratch_r[src_raddr];
  end

  // Count and set tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      set_open_r <= 1'b0;
    end else if (cmd.load) begin
      count_r    <= cnt_new;
      set_open_r <= !in_last;
    end
  end

  // Pass and segment control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= '0;
      dir_r <= 1'b0;
    end else if (cmd.sort_init) begin
      w_r   <= PW'(1);
      dir_r <= 1'b0;
    end else if (cmd.merge && st.seg_end && st.pass_end) begin
      w_r   <= w_r << 1;
      dir_r <= !dir_r;
    end
  end

  // Merge pointers and run heads
  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      lo_r    <= rstart_ext[AW-1:0];
      hi_r    <= hi_cand[AW-1:0];
      seg_l_r <= PW'(rstart_ext[AW-1:0]);
    end
    if (cmd.seg_start) begin
      seg_mid_r <= mid_c;
      seg_hi_r  <= sh_c;
      a_r       <= seg_l_r;
      b_r       <= mid_c + PW'(1);
      k_r       <= seg_l_r;
    end
    if (cmd.seg_second) begin
      head_l_r    <= src_rdata;
      pend_left_r <= 1'b0;
    end
    if (cmd.merge) begin
      k_r <= k_r + PW'(1);
      if (take_l) begin
        a_r         <= a_r + PW'(1);
        head_r_r    <= eff_r;
        pend_left_r <= 1'b1;
      end else begin
        b_r         <= b_r + PW'(1);
        head_l_r    <= eff_l;
        pend_left_r <= 1'b0;
      end
      if (st.seg_end) begin
        seg_l_r <= st.pass_end ? PW'(lo_r) : seg_hi_r + PW'(1);
      end
    end
  end

  // Hold a read result until the output register is free
  assign move = pend_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.read) begin
        pend_r <= 1'b1;
      end else if (move) begin
        pend_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) pend_oor_r <= !hit;
    if (move)     out_elem_r <= pend_oor_r ? '0 : a_rdata_r;
    if (move)     out_oor_r  <= pend_oor_r;
  end

  assign out_valid    = out_valid_r;
  assign out_element  = out_elem_r;
  assign out_of_range = out_oor_r;

  always_comb begin
    st             = '0;
    st.pend        = pend_r;
    st.sort_go     = rstart_ext < hi_cand;
    st.pass_finish = (w_r >= len) && !dir_r;
    st.seg_end     = k_r == seg_hi_r;
    st.pass_end    = seg_hi_r == hi_ext;
  end

endmodule

// ===== rtl/merge_sort_range_top.sv =====
// Read item: the element is registered and held as pending until the output register is free;
// the next request is held off until the result has entered the output register.
// Sort after a last load: bottom-up merge over n = end-start+1 entries (end clamped to the
// last loaded entry), one element per merge cycle, with ceil(log2 n) passes rounded up
// to an even count so that the result ends in the element store.
// Reset (synchronous, rst_n low): count, set state and handshake clear, range returns to 0..1023; stores kept.
module merge_sort_range_top #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  msr_in_if.sink                      in_req,
  msr_out_if.source                   out_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msr_pkg::CFG_AW-1:0]  paddr,
  input  logic [msr_pkg::CFG_DW-1:0]  pwdata,
  output logic [msr_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  msr_pkg::range_t    range_start;
  msr_pkg::range_t    range_end;
  msr_pkg::msr_cmd_t  cmd;
  msr_pkg::msr_stat_t st;
  logic               in_ready;
  logic               out_valid;
  msr_pkg::elem_t     out_element;
  logic               out_oor;

  msr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .range_start (range_start),
    .range_end   (range_end)
  );

  msr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_req.valid),
    .in_operation (in_req.operation),
    .in_last      (in_req.last),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .st           (st)
  );

  msr_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .in_value     (in_req.value),
    .in_last      (in_req.last),
    .in_index     (in_req.index),
    .range_start  (range_start),
    .range_end    (range_end),
    .out_valid    (out_valid),
    .out_ready    (out_res.ready),
    .out_element  (out_element),
    .out_of_range (out_oor)
  );

  assign in_req.ready         = in_ready;
  assign out_res.valid        = out_valid;
  assign out_res.element      = out_element;
  assign out_res.out_of_range = out_oor;

endmodule

// ===== rtl/msr_checker.sv =====
// Port-level checks for the merge sort range block, bound to the top level.
// Depends on msr_pkg for the operation codes.
module msr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           in_operation,
  input logic           out_valid,
  input logic           out_ready,
  input msr_pkg::elem_t out_element,
  input logic           out_oor
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_element) && $stable(out_oor))
    else $error("stalled result changed");

  // An out of range result carries a zero element
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_oor |-> out_element == '0)
    else $error("out of range result with non-zero element");

  // A read request occupies the result path for the next cycle
  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == msr_pkg::OP_READ) |=> !in_ready)
    else $error("request taken while a read result is pending");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind merge_sort_range_top msr_checker u_msr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .in_operation (in_req.operation),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .out_element  (out_res.element),
  .out_oor      (out_res.out_of_range)
);

// ===== dv/merge_sort_range_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for merge_sort_range_top: loads, range sorts and read-back.
// Depends on msr_pkg and the msr_in_if / msr_out_if channel interfaces.
module merge_sort_range_top_tb;

  localparam int MAX_ELEMS   = 1024;
  localparam int QUIET_LIMIT = 40000;
  localparam int HOLD_CYCLES = 400;
  localparam int N_PHASES    = 12;

  typedef struct packed {
    logic            op;
    msr_pkg::elem_t  value;
    logic            last;
    msr_pkg::range_t index;
  } req_t;

  typedef struct packed {
    msr_pkg::elem_t element;
    logic           oor;
  } res_t;

  typedef struct packed {
    logic            op;
    msr_pkg::elem_t  value;
    logic            last;
    msr_pkg::range_t index;
    bit              typed;
    msr_pkg::elem_t  exp_element;
    logic            exp_oor;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [msr_pkg::CFG_AW-1:0] paddr;
  logic [msr_pkg::CFG_DW-1:0] pwdata;
  logic [msr_pkg::CFG_DW-1:0] prdata;
  logic pready;

  msr_in_if  req_if();
  msr_out_if res_if();

  merge_sort_range_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_res (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block: element store, count, set state and range registers
  msr_pkg::elem_t shadow_mem [MAX_ELEMS];
  int    shadow_count;
  bit    shadow_open;
  int    shadow_start;
  int    shadow_end;
  res_t  read_expect_q [$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_seq     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int errors       = 0;
  int cfg_errors;
  int quiet_cycles = 0;
  int phase_items;
  res_t got_exp;

  // Short smoke test: extremes, single-element set, reads in an open set
  dir_row_t dir_rows [22] = '{
    '{msr_pkg::OP_READ, 32'sd0,        1'b0, 10'd0,    1'b1, 32'sd0,        1'b1},
    '{msr_pkg::OP_READ, -32'sd1,       1'b1, 10'd1023, 1'b1, 32'sd0,        1'b1},
    '{msr_pkg::OP_LOAD, 32'sh7FFFFFFF, 1'b0, 10'd1023, 1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_LOAD, 32'sh80000000, 1'b0, 10'd0,    1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_LOAD, -32'sd1,       1'b0, 10'd512,  1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_LOAD, 32'sd0,        1'b0, 10'd341,  1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_LOAD, 32'sd5,        1'b0, 10'd682,  1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_LOAD, 32'sd1,        1'b0, 10'd0,    1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_LOAD, 32'sd5,        1'b1, 10'd1023, 1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_READ, 32'sd0,        1'b0, 10'd0,    1'b1, 32'sh80000000, 1'b0},
    '{msr_pkg::OP_READ, 32'sd0,        1'b0, 10'd6,    1'b1, 32'sh7FFFFFFF, 1'b0},
    '{msr_pkg::OP_READ, 32'sd0,        1'b0, 10'd3,    1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_READ, 32'sd0,        1'b0, 10'd7,    1'b1, 32'sd0,        1'b1},
    '{msr_pkg::OP_LOAD, 32'sd42,       1'b1, 10'd5,    1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_READ, 32'sd0,        1'b0, 10'd0,    1'b1, 32'sd42,       1'b0},
    '{msr_pkg::OP_READ, 32'sd0,        1'b0, 10'd1,    1'b1, 32'sd0,        1'b1},
    '{msr_pkg::OP_LOAD, 32'sd9,        1'b0, 10'd0,    1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_LOAD, 32'sd3,        1'b0, 10'd0,    1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_READ, 32'sd0,        1'b0, 10'd1,    1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_LOAD, -32'sd7,       1'b1, 10'd0,    1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_READ, 32'sd0,        1'b0, 10'd0,    1'b0, 32'sd0,        1'b0},
    '{msr_pkg::OP_READ, 32'sd0,        1'b0, 10'd2,    1'b0, 32'sd0,        1'b0}
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one accepted request to the shadow; a read yields the expected result
  function automatic void shadow_request(input req_t r, output bit has_res, output res_t res);
    int             hi;
    int             j;
    msr_pkg::elem_t key;
    has_res = 1'b0;
    res     = '0;
    if (r.op == msr_pkg::OP_LOAD) begin
      if (!shadow_open) begin
        shadow_count = 0;
        shadow_open  = 1'b1;
      end
      // drop the value once the store is full, but still honour last
      if (shadow_count < MAX_ELEMS) begin
        shadow_mem[shadow_count] = r.value;
        shadow_count++;
      end
      if (r.last) begin
        shadow_open = 1'b0;
        if (shadow_count > 0) begin
          hi = (shadow_end > shadow_count - 1) ? shadow_count - 1 : shadow_end;
          // stable ascending sort of the clamped range
          for (int i = shadow_start + 1; i <= hi && shadow_start < hi; i++) begin
            key = shadow_mem[i];
            j   = i - 1;
            while (j >= shadow_start && shadow_mem[j] > key) begin
              shadow_mem[j + 1] = shadow_mem[j];
              j--;
            end
            shadow_mem[j + 1] = key;
          end
        end
      end
    end else begin
      has_res = 1'b1;
      if (int'(r.index) < shadow_count) begin
        res.element = shadow_mem[r.index];
        res.oor     = 1'b0;
      end else begin
        res.element = '0;
        res.oor     = 1'b1;
      end
    end
  endfunction

  function automatic msr_pkg::elem_t rand_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      4, 5: return msr_pkg::elem_t'($urandom_range(0, 16)) - 32'sd8;
      default: return msr_pkg::elem_t'($urandom);
    endcase
  endfunction

  // Offer one request, hold it until accepted, then record what it should return
  task automatic send_request(input req_t r, input bit typed, input res_t typed_res);
    bit   has_res;
    res_t res;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= r.op;
    req_if.value     <= r.value;
    req_if.last      <= r.last;
    req_if.index     <= r.index;
    do @(posedge clk); while (!req_if.ready);
    shadow_request(r, has_res, res);
    if (has_res) read_expect_q.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // Read request: mostly inside the loaded count, sometimes at or beyond it
  task automatic send_read();
    req_t r;
    int   pick;
    pick    = $urandom_range(0, 9);
    r.op    = msr_pkg::OP_READ;
    r.value = msr_pkg::elem_t'($urandom);
    r.last  = 1'($urandom_range(0, 1));
    if (pick == 0 || shadow_count == 0) r.index = msr_pkg::range_t'($urandom_range(0, 1023));
    else if (pick == 1) r.index = msr_pkg::range_t'(shadow_count);
    else r.index = msr_pkg::range_t'($urandom_range(0, shadow_count - 1));
    send_request(r, 1'b0, '0);
    phase_items++;
  endtask

  // One data set: loads with stray reads in between, closed by last, then reads
  task automatic run_set(input int n_loads, input int n_reads);
    req_t r;
    for (int i = 0; i < n_loads; i++) begin
      if ($urandom_range(0, 99) < 8) send_read();
      r.op    = msr_pkg::OP_LOAD;
      r.value = rand_value();
      r.last  = (i == n_loads - 1);
      r.index = msr_pkg::range_t'($urandom_range(0, 1023));
      send_request(r, 1'b0, '0);
      phase_items++;
    end
    repeat (n_reads) send_read();
  endtask

  task automatic cfg_xfer(input bit wr, input logic sel, input msr_pkg::range_t wval,
                          output logic [msr_pkg::CFG_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= msr_pkg::CFG_DW'(wval);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_check(input logic sel, input msr_pkg::range_t exp_val);
    logic [msr_pkg::CFG_DW-1:0] d;
    cfg_xfer(1'b0, sel, '0, d);
    if (d !== msr_pkg::CFG_DW'(exp_val)) begin
      $error("%s readback mismatch: expected %0d, got %0d",
             (sel == msr_pkg::REG_RANGE_END) ? "range_end" : "range_start", exp_val, d);
      cfg_errors++;
    end
  endtask

  task automatic reg_write(input logic sel, input msr_pkg::range_t val);
    logic [msr_pkg::CFG_DW-1:0] d;
    cfg_xfer(1'b1, sel, val, d);
    if (sel == msr_pkg::REG_RANGE_END) shadow_end = val;
    else shadow_start = val;
    reg_check(sel, val);
  endtask

  // Drain results, let any sort finish, then move the range
  task automatic reconfigure(input int s, input int e);
    req_if.valid <= 1'b0;
    while (read_expect_q.size() != 0) @(negedge clk);
    repeat (12 * shadow_count + 64) @(negedge clk);
    reg_write(msr_pkg::REG_RANGE_START, msr_pkg::range_t'(s));
    reg_write(msr_pkg::REG_RANGE_END, msr_pkg::range_t'(e));
  endtask

  // Result ready; a hold-off request keeps it low for a long stretch
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Compare each returned result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (read_expect_q.size() == 0) begin
        $error("unexpected result: element %0d out_of_range %0b",
               res_if.element, res_if.out_of_range);
        errors++;
      end else begin
        got_exp = read_expect_q.pop_front();
        if (res_if.element !== got_exp.element) begin
          $error("element mismatch: expected %0d, got %0d", got_exp.element, res_if.element);
          errors++;
        end
        if (res_if.out_of_range !== got_exp.oor) begin
          $error("out_of_range mismatch: expected %0b, got %0b",
                 got_exp.oor, res_if.out_of_range);
          errors++;
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stim
    req_t r;
    res_t tr;
    int   s;
    int   e;
    int   pick;
    int   n;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_if.valid     = 1'b0;
    req_if.operation = msr_pkg::OP_LOAD;
    req_if.value     = '0;
    req_if.last      = 1'b0;
    req_if.index     = '0;
    cfg_errors       = 0;
    phase_items      = 0;
    shadow_count     = 0;
    shadow_open      = 1'b0;
    shadow_start     = msr_pkg::RANGE_START_RST;
    shadow_end       = msr_pkg::RANGE_END_RST;
    snd_idle_pct     = 14;
    rcv_idle_pct     = 48;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    reg_check(msr_pkg::REG_RANGE_START, msr_pkg::RANGE_START_RST);
    reg_check(msr_pkg::REG_RANGE_END, msr_pkg::RANGE_END_RST);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      r.op           = dir_rows[i].op;
      r.value        = dir_rows[i].value;
      r.last         = dir_rows[i].last;
      r.index        = dir_rows[i].index;
      tr.element     = dir_rows[i].exp_element;
      tr.oor         = dir_rows[i].exp_oor;
      send_request(r, dir_rows[i].typed, tr);
    end

    // Random phases, each under its own range setting; the idling mode changes every four phases
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 4) begin
        snd_idle_pct = 14;
        rcv_idle_pct = 48;
      end else if (ph < 8) begin
        snd_idle_pct = 48;
        rcv_idle_pct = 14;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      s = $urandom_range(0, 12);
      e = $urandom_range(0, 1) ? $urandom_range(0, 1023) : s + $urandom_range(0, 30);
      case (ph)
        0, 8: begin s = 0; e = 1023; end
        1: begin s = 0; e = 0; end
        2: begin s = 2; e = 9; end
        4: begin s = 1023; e = 1023; end
        5: begin s = 1023; e = 0; end
        6: begin s = 3; e = 3; end
        10: begin s = 1; e = 1022; end
        default: ;
      endcase
      reconfigure(s, e);
      phase_items = 0;
      if (ph == 8) begin
        // overfill the store so that trailing loads are dropped
        run_set(MAX_ELEMS + 6, 30);
      end else begin
        if (ph == 9) begin
          hold_seq++;
          run_set(4, 24);
        end
        while (phase_items < 40) begin
          pick = $urandom_range(0, 9);
          n = (pick < 7) ? $urandom_range(1, 16) :
              (pick < 9) ? $urandom_range(17, 48) : $urandom_range(49, 200);
          run_set(n, $urandom_range(1, 10));
        end
      end
    end

    // Drain and settle
    req_if.valid <= 1'b0;
    while (read_expect_q.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    if (errors == 0 && cfg_errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
